### rtl/pts_pkg.sv
package pts_pkg;

    // Default size of the distinct source table.
    localparam int unsigned DefaultSourceTableDepth = 64;

    // Field widths fixed by the packet header layout.
    localparam int unsigned CountWidth    = 32;
    localparam int unsigned DistinctWidth = 7;
    localparam int unsigned DistinctMax   = 127;

    // IPv4 protocol numbers, ICMP type and TCP flag patterns of interest.
    localparam logic [7:0] ProtoIcmp     = 8'h01;
    localparam logic [7:0] ProtoTcp      = 8'h06;
    localparam logic [7:0] ProtoUdp      = 8'h11;
    localparam logic [7:0] IcmpEchoReply = 8'h00;
    localparam logic [7:0] FlagSynOnly   = 8'h02;
    localparam logic [7:0] FlagAckOnly   = 8'h10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the packet source and update the counters
        logic emit;      // load the result register and clear the window
        logic rd_first;  // read table entry zero
        logic rd_next;   // read the entry after the current one
        logic insert;    // append the latched source to the table
        logic overflow;  // record that a new source found the table full
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_zero; // table holds no entry in this window
        logic hit;       // entry just read equals the latched source
        logic last;      // entry just read is the last filled one
        logic full;      // table holds its full depth
    } t_status;

    // Counter increment that stops at the all-ones value.
    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] value);
        sat_inc = (&value) ? value : value + CountWidth'(1);
    endfunction

endpackage

### rtl/packet_traffic_statistics_unit.sv
// Packet traffic statistics over a window. Each packet beat updates saturating
// counters for all packets, TCP, SYN-only, ACK-only, UDP and ICMP echo replies,
// and looks its IPv4 source up in a table of distinct sources, appending it when
// new or flagging overflow when the table is full. A close-window beat emits one
// result with the counts and clears the window. A packet beat compares table
// entries with its source up to and including a match, or every filled entry
// on a miss, and goes straight to insertion when the table is empty. The search
// runs through the single read port of the source table, one entry a cycle. A
// close-window beat is held off while a packet lookup is still in progress or
// while the previous result is still waiting to be taken; packet beats keep
// flowing while a result waits.
module packet_traffic_statistics_unit import pts_pkg::*; #(
    parameter int unsigned SOURCE_TABLE_DEPTH = DefaultSourceTableDepth
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_command,
    input  logic [7:0]               i_ip_protocol,
    input  logic [7:0]               i_icmp_type,
    input  logic [7:0]               i_tcp_flag_bits,
    input  logic [31:0]              i_source_address,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CountWidth-1:0]    o_packets_seen,
    output logic [CountWidth-1:0]    o_tcp_packets,
    output logic [CountWidth-1:0]    o_syn_only_packets,
    output logic [CountWidth-1:0]    o_ack_only_packets,
    output logic [CountWidth-1:0]    o_udp_packets,
    output logic [CountWidth-1:0]    o_echo_replies,
    output logic [DistinctWidth-1:0] o_distinct_sources,
    output logic                     o_source_overflow
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer for capture, table search, insertion and window close.
    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_command(i_command),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Counters, source table and result register.
    pts_datapath #(
        .SOURCE_TABLE_DEPTH(SOURCE_TABLE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_ip_protocol     (i_ip_protocol),
        .i_icmp_type       (i_icmp_type),
        .i_tcp_flag_bits   (i_tcp_flag_bits),
        .i_source_address  (i_source_address),
        .o_status          (w_status),
        .o_packets_seen    (o_packets_seen),
        .o_tcp_packets     (o_tcp_packets),
        .o_syn_only_packets(o_syn_only_packets),
        .o_ack_only_packets(o_ack_only_packets),
        .o_udp_packets     (o_udp_packets),
        .o_echo_replies    (o_echo_replies),
        .o_distinct_sources(o_distinct_sources),
        .o_source_overflow (o_source_overflow)
    );

    // An entry is never appended to a full table.
    a_no_insert_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.insert |-> !w_status.full)
        else $error("source appended to a full table");

    // A window close never overwrites a result that is still held.
    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !(o_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // An accepted packet beat always holds off the next beat for its lookup.
    a_packet_blocks_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_command) |=> o_in_stall)
        else $error("packet lookup did not hold off the input");

    // A new result only appears after a window close.
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.emit))
        else $error("result valid without a window close");

endmodule

### rtl/pts_ram.sv
module pts_ram import pts_pkg::*; #(
    parameter int unsigned WIDTH = CountWidth,
    parameter int unsigned DEPTH = DefaultSourceTableDepth
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pts_ctrl.sv
module pts_ctrl import pts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_command,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_INSERT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    // Any beat waits during a lookup; a close beat also waits while an earlier result is still held.
    assign o_in_stall = (r_state != S_IDLE) || (i_in_command && r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_command) begin
                        o_cmd.emit = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        if (i_status.fill_zero) begin
                            n_state = S_INSERT;
                        end else begin
                            o_cmd.rd_first = 1'b1;
                            n_state        = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH: begin
                if (i_status.hit) begin
                    n_state = S_IDLE;
                end else if (i_status.last) begin
                    if (i_status.full) begin
                        o_cmd.overflow = 1'b1;
                    end else begin
                        o_cmd.insert = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result stays valid until the downstream side takes the beat.
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/pts_datapath.sv
module pts_datapath import pts_pkg::*; #(
    parameter int unsigned SOURCE_TABLE_DEPTH = DefaultSourceTableDepth
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [7:0]               i_ip_protocol,
    input  logic [7:0]               i_icmp_type,
    input  logic [7:0]               i_tcp_flag_bits,
    input  logic [31:0]              i_source_address,
    output t_status                  o_status,
    output logic [CountWidth-1:0]    o_packets_seen,
    output logic [CountWidth-1:0]    o_tcp_packets,
    output logic [CountWidth-1:0]    o_syn_only_packets,
    output logic [CountWidth-1:0]    o_ack_only_packets,
    output logic [CountWidth-1:0]    o_udp_packets,
    output logic [CountWidth-1:0]    o_echo_replies,
    output logic [DistinctWidth-1:0] o_distinct_sources,
    output logic                     o_source_overflow
);

    localparam int unsigned AW = (SOURCE_TABLE_DEPTH > 1) ? $clog2(SOURCE_TABLE_DEPTH) : 1;
    localparam int unsigned FW = $clog2(SOURCE_TABLE_DEPTH + 1);

    logic [CountWidth-1:0] r_cnt_packets;
    logic [CountWidth-1:0] r_cnt_tcp;
    logic [CountWidth-1:0] r_cnt_syn;
    logic [CountWidth-1:0] r_cnt_ack;
    logic [CountWidth-1:0] r_cnt_udp;
    logic [CountWidth-1:0] r_cnt_echo;
    logic [FW-1:0]         r_fill;
    logic                  r_overflow;
    logic [31:0]           r_addr;
    logic [AW-1:0]         r_rd_idx;
    logic [AW-1:0]         rd_addr;
    logic                  rd_en;
    logic [31:0]           ram_q;
    logic [31:0]           fill_ext;

    logic [CountWidth-1:0]    r_out_packets;
    logic [CountWidth-1:0]    r_out_tcp;
    logic [CountWidth-1:0]    r_out_syn;
    logic [CountWidth-1:0]    r_out_ack;
    logic [CountWidth-1:0]    r_out_udp;
    logic [CountWidth-1:0]    r_out_echo;
    logic [DistinctWidth-1:0] r_out_distinct;
    logic                     r_out_overflow;

    // Search address: entry zero at the start, then one entry a cycle.
    assign rd_en   = i_cmd.rd_first || i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_first ? '0 : r_rd_idx + AW'(1);

    pts_ram #(
        .WIDTH(32),
        .DEPTH(SOURCE_TABLE_DEPTH)
    ) u_source_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.insert),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(r_addr),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    // Status seen by the controller; the read data belongs to r_rd_idx.
    assign o_status.fill_zero = (r_fill == '0);
    assign o_status.hit       = (ram_q == r_addr);
    assign o_status.last      = (FW'(r_rd_idx) == r_fill - FW'(1));
    assign o_status.full      = (32'(r_fill) == 32'(SOURCE_TABLE_DEPTH));

    // Latched source and search index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_source_address;
        end
        if (rd_en) begin
            r_rd_idx <= rd_addr;
        end
    end

    // Window counters, fill count and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_packets <= '0;
            r_cnt_tcp     <= '0;
            r_cnt_syn     <= '0;
            r_cnt_ack     <= '0;
            r_cnt_udp     <= '0;
            r_cnt_echo    <= '0;
            r_fill        <= '0;
            r_overflow    <= 1'b0;
        end else if (i_cmd.emit) begin
            r_cnt_packets <= '0;
            r_cnt_tcp     <= '0;
            r_cnt_syn     <= '0;
            r_cnt_ack     <= '0;
            r_cnt_udp     <= '0;
            r_cnt_echo    <= '0;
            r_fill        <= '0;
            r_overflow    <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cnt_packets <= sat_inc(r_cnt_packets);
                if (i_ip_protocol == ProtoIcmp) begin
                    if (i_icmp_type == IcmpEchoReply) begin
                        r_cnt_echo <= sat_inc(r_cnt_echo);
                    end
                end else if (i_ip_protocol == ProtoTcp) begin
                    r_cnt_tcp <= sat_inc(r_cnt_tcp);
                    if (i_tcp_flag_bits == FlagSynOnly) begin
                        r_cnt_syn <= sat_inc(r_cnt_syn);
                    end else if (i_tcp_flag_bits == FlagAckOnly) begin
                        r_cnt_ack <= sat_inc(r_cnt_ack);
                    end
                end else if (i_ip_protocol == ProtoUdp) begin
                    r_cnt_udp <= sat_inc(r_cnt_udp);
                end
            end
            if (i_cmd.insert) begin
                r_fill <= r_fill + FW'(1);
            end
            if (i_cmd.overflow) begin
                r_overflow <= 1'b1;
            end
        end
    end

    // Result register, loaded when a window closes.
    assign fill_ext = 32'(r_fill);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_packets  <= r_cnt_packets;
            r_out_tcp      <= r_cnt_tcp;
            r_out_syn      <= r_cnt_syn;
            r_out_ack      <= r_cnt_ack;
            r_out_udp      <= r_cnt_udp;
            r_out_echo     <= r_cnt_echo;
            r_out_distinct <= (fill_ext > 32'(DistinctMax)) ? DistinctWidth'(DistinctMax)
                                                            : fill_ext[DistinctWidth-1:0];
            r_out_overflow <= r_overflow;
        end
    end

    assign o_packets_seen     = r_out_packets;
    assign o_tcp_packets      = r_out_tcp;
    assign o_syn_only_packets = r_out_syn;
    assign o_ack_only_packets = r_out_ack;
    assign o_udp_packets      = r_out_udp;
    assign o_echo_replies     = r_out_echo;
    assign o_distinct_sources = r_out_distinct;
    assign o_source_overflow  = r_out_overflow;

endmodule
